### src/ftt_pkg.sv
// ----------------------------------------------------------------------------
// Fencing token table package
// Shared widths, codes and the request packet that travels along the cells.
// ----------------------------------------------------------------------------
package ftt_pkg;

  localparam int ENTRIES = 64;

  localparam int CMD_W    = 2;
  localparam int NIC_W    = 8;
  localparam int DEV_W    = 16;
  localparam int PORT_W   = 8;
  localparam int TOKEN_W  = 64;
  localparam int STATUS_W = 2;
  localparam int KEY_W    = NIC_W + DEV_W + 1 + PORT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_OBSERVE,
    CMD_QUERY,
    CMD_ADVANCE
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_EXHAUSTED,
    ST_FULL
  } status_t;

  typedef struct packed {
    logic               vld;
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [TOKEN_W-1:0] token;
    logic               done;
    status_t            status;
  } pkt_t;

endpackage

### src/ftt_if.sv
// ----------------------------------------------------------------------------
// Fencing token table channels
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface ftt_in_if;
  import ftt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [NIC_W-1:0]    nic_id;
  logic [DEV_W-1:0]    device_id;
  logic                port_given;
  logic [PORT_W-1:0]   port_id;
  logic [TOKEN_W-1:0]  token_in;

  modport source (output valid, command, nic_id, device_id, port_given, port_id, token_in,
                  input ready);
  modport sink (input valid, command, nic_id, device_id, port_given, port_id, token_in,
                output ready);
endinterface

interface ftt_out_if;
  import ftt_pkg::*;

  logic                valid;
  logic                ready;
  logic [TOKEN_W-1:0]  token_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, token_out, status, input ready);
  modport sink (input valid, token_out, status, output ready);
endinterface

### src/ftt_cell.sv
// ----------------------------------------------------------------------------
// Fencing token table cell
// Holds one scope entry and serves the request packet passing through it.
// ----------------------------------------------------------------------------
module ftt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  ftt_pkg::pkt_t pkt_i,
  output ftt_pkg::pkt_t pkt_o,
  output logic          entry_vld_o
);
  import ftt_pkg::*;

  logic               vld_r, vld_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [TOKEN_W-1:0] tok_r, tok_nxt;
  logic               pkt_vld_r;
  pkt_t               pkt_r, pkt_nxt;
  logic               active;
  logic               hit;
  logic [TOKEN_W-1:0] tok_inc;

  assign active  = pkt_i.vld && !pkt_i.done;
  assign hit     = vld_r && (key_r == pkt_i.key);
  assign tok_inc = tok_r + TOKEN_W'(1);

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    tok_nxt = tok_r;
    pkt_nxt = pkt_i;
    priority if (active && hit) begin
      pkt_nxt.done   = 1'b1;
      pkt_nxt.token  = '0;
      pkt_nxt.status = ST_OK;
      unique case (pkt_i.cmd)
        CMD_OBSERVE: begin
          if (pkt_i.token > tok_r) begin
            tok_nxt = pkt_i.token;
          end
        end
        CMD_QUERY: begin
          pkt_nxt.token = tok_r;
        end
        CMD_ADVANCE: begin
          if (&tok_r) begin
            pkt_nxt.status = ST_EXHAUSTED;
          end else begin
            tok_nxt       = tok_inc;
            pkt_nxt.token = tok_inc;
          end
        end
        default: begin
          pkt_nxt.status = ST_NOT_FOUND;
        end
      endcase
    end else if (active && !vld_r) begin
      pkt_nxt.done   = 1'b1;
      pkt_nxt.token  = '0;
      pkt_nxt.status = ST_OK;
      unique case (pkt_i.cmd)
        CMD_OBSERVE: begin
          vld_nxt = 1'b1;
          key_nxt = pkt_i.key;
          tok_nxt = pkt_i.token;
        end
        CMD_ADVANCE: begin
          vld_nxt       = 1'b1;
          key_nxt       = pkt_i.key;
          tok_nxt       = TOKEN_W'(1);
          pkt_nxt.token = TOKEN_W'(1);
        end
        default: begin
          pkt_nxt.status = ST_NOT_FOUND;
        end
      endcase
    end else begin
      pkt_nxt = pkt_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      pkt_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= vld_nxt;
      pkt_vld_r <= pkt_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_nxt;
      tok_r <= tok_nxt;
      pkt_r <= pkt_nxt;
    end
  end

  always_comb begin
    pkt_o     = pkt_r;
    pkt_o.vld = pkt_vld_r;
  end

  assign entry_vld_o = vld_r;

endmodule

### src/fencing_token_table.sv
// ----------------------------------------------------------------------------
// Fencing token table
// Ledger of exclusive scopes, each mapped to the highest fencing token seen.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (command, scope and token) and each gives exactly
// one result on out_ch (token and status), in request order.
// Each request enters a row of ENTRIES cells, one per table slot, and moves
// one cell per cycle unless the row stalls; the cell holding its scope, or
// else the first free cell, serves it. Slots fill from the lowest index and
// are never freed. Results are registered once more after the last cell.
// One request is taken every cycle unless the row stalls, since every
// request visits the cells in order behind the one before it.
// A synchronous active-low reset empties the table and the row; nothing else
// needs clearing, as slot contents are read only once written.
// When the receiver stalls, the whole row holds and in_ch.ready falls until
// the waiting result is transferred.
// ----------------------------------------------------------------------------
module fencing_token_table (
  input logic       clk,
  input logic       rst_n,
  ftt_in_if.sink    in_ch,
  ftt_out_if.source out_ch
);
  import ftt_pkg::*;

  logic                adv;
  pkt_t                head;
  pkt_t                pkt [ENTRIES+1];
  logic [ENTRIES-1:0]  entry_vld;
  logic                out_vld_r;
  logic [TOKEN_W-1:0]  token_out_r, token_out_nxt;
  status_t             status_r, status_nxt;
  pkt_t                last;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    head.vld    = in_ch.valid && adv;
    head.cmd    = in_ch.command;
    head.key    = {in_ch.nic_id, in_ch.device_id, in_ch.port_given,
                   in_ch.port_given ? in_ch.port_id : PORT_W'(0)};
    head.token  = (in_ch.command == CMD_OBSERVE) ? in_ch.token_in : '0;
    head.done   = !((in_ch.command == CMD_OBSERVE) || (in_ch.command == CMD_QUERY) ||
                    (in_ch.command == CMD_ADVANCE));
    head.status = ST_NOT_FOUND;
  end

  assign pkt[0] = head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ftt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .pkt_i       (pkt[i]),
      .pkt_o       (pkt[i+1]),
      .entry_vld_o (entry_vld[i])
    );
  end

  assign last = pkt[ENTRIES];

  always_comb begin
    token_out_nxt = '0;
    status_nxt    = ST_FULL;
    priority if (last.done) begin
      token_out_nxt = last.token;
      status_nxt    = last.status;
    end else if (last.cmd == CMD_QUERY) begin
      status_nxt = ST_NOT_FOUND;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      token_out_r <= token_out_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.token_out = token_out_r;
  assign out_ch.status    = status_r;

  a_slots_fill_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_vld[ENTRIES-1:1] & ~entry_vld[ENTRIES-2:0]) == '0)
    else $error("table slots are not filled from the lowest index");

  a_stall_freezes_table: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(entry_vld))
    else $error("table changed while the row was stalled");

  a_failed_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.token_out == '0))
    else $error("failed result carries a non-zero token");

  a_stall_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("request taken while a result transfer is stalled");

endmodule
